### design/kts_pkg.sv
// shared constants, codes and types of the keyed table search unit
`timescale 1ns / 1ps

package kts_pkg;

   // table geometry
   localparam int DEPTH       = 64;
   localparam int MAX_RESULTS = 64;
   localparam int IDX_W       = $clog2(DEPTH);
   localparam int CNT_W       = $clog2(DEPTH + 1);
   localparam int EMIT_W      = $clog2(MAX_RESULTS + 1);

   // field widths
   localparam int ACT_W  = 2;
   localparam int KEY_W  = 20;
   localparam int NAME_W = 32;
   localparam int POS_W  = 6;
   localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

   // action codes
   typedef logic [ACT_W-1:0] action_type;
   localparam action_type ACT_APPEND = 2'd0;
   localparam action_type ACT_SEARCH = 2'd1;
   localparam action_type ACT_READ   = 2'd2;

   // result status codes
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2,
      ST_EMPTY     = 2'd3
   } status_type;

   // one stored record
   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [NAME_W-1:0] name;
   } record_type;

   // control of one chain of cells
   typedef struct packed {
      logic             shift;
      logic             load;
      logic [IDX_W-1:0] load_idx;
   } chain_ctrl_type;

   // channel payloads
   typedef struct packed {
      action_type        action;
      logic [KEY_W-1:0]  key_in;
      logic [NAME_W-1:0] name_handle_in;
      logic [POS_W-1:0]  position_in;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [KEY_W-1:0]  key_out;
      logic [NAME_W-1:0] name_handle_out;
      logic              last;
   } rsp_type;

endpackage

### design/kts_if.sv
// request and response channel interfaces
`timescale 1ns / 1ps

interface kts_req_if;
   logic              valid;
   logic              ready;
   kts_pkg::req_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface kts_rsp_if;
   logic              valid;
   logic              ready;
   kts_pkg::rsp_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### design/kts_cell.sv
// one record cell: loads a broadcast record or takes its neighbor's
`timescale 1ns / 1ps

module kts_cell (
   input  logic                clock,
   input  logic                shift_en,
   input  logic                load_en,
   input  kts_pkg::record_type shift_data,
   input  kts_pkg::record_type load_data,
   output kts_pkg::record_type data
);

   kts_pkg::record_type data_ff;
   kts_pkg::record_type data_in;

   // load wins over shift
   always_comb begin
      data_in = data_ff;
      if (load_en) begin
         data_in = load_data;
      end else if (shift_en) begin
         data_in = shift_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

### design/kts_chain.sv
// row of record cells shifting toward the head, with an indexed load
`timescale 1ns / 1ps

module kts_chain (
   input  logic                    clock,
   input  kts_pkg::chain_ctrl_type ctrl,
   input  kts_pkg::record_type     load_data,
   output kts_pkg::record_type     head
);

   kts_pkg::record_type cell_q   [kts_pkg::DEPTH];
   kts_pkg::record_type cell_nxt [kts_pkg::DEPTH];

   genvar j;
   generate
      for (j = 0; j < kts_pkg::DEPTH; j++) begin : g_cell
         // neighbor feed; the tail cell keeps its own record
         if (j == kts_pkg::DEPTH - 1) begin : g_tail
            assign cell_nxt[j] = cell_q[j];
         end else begin : g_mid
            assign cell_nxt[j] = cell_q[j+1];
         end

         kts_cell u_cell (
            .clock      (clock),
            .shift_en   (ctrl.shift),
            .load_en    (ctrl.load && (ctrl.load_idx == kts_pkg::IDX_W'(j))),
            .shift_data (cell_nxt[j]),
            .load_data  (load_data),
            .data       (cell_q[j])
         );
      end
   endgenerate

   assign head = cell_q[0];

endmodule

### design/keyed_table_search_move_to_front_unit.sv
// Keyed record table with move-to-front search, built as two chains of cells.
// The table lives in a chain of DEPTH cells that shifts toward its head; a second
// chain of DEPTH cells holds the unmatched records while a search runs. A read of
// position p steps the table once around its n stored records. A search pops each
// of the n records at the head in turn (one per cycle while the output register is
// free), puts matches back at the table's tail and unmatched ones into the second
// chain, then drains that chain back behind the matches. Results leave through an
// output register; a read or a search stalls only while that register holds a
// result not yet taken.
`timescale 1ns / 1ps

module keyed_table_search_move_to_front_unit (
   input  logic      clock,
   input  logic      reset,
   kts_req_if.sink   req_bus,
   kts_rsp_if.source rsp_bus
);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_SCAN   = 5'b00010,
      S_DRAIN  = 5'b00100,
      S_READ   = 5'b01000,
      S_FINISH = 5'b10000
   } state_type;

   state_type                    state_ff, state_in;
   logic [kts_pkg::CNT_W-1:0]    count_ff, count_in;
   logic [kts_pkg::CNT_W-1:0]    mocc_ff, mocc_in;
   logic [kts_pkg::CNT_W-1:0]    wocc_ff, wocc_in;
   logic [kts_pkg::CNT_W-1:0]    step_ff, step_in;
   logic [kts_pkg::EMIT_W-1:0]   emit_ff, emit_in;
   logic [kts_pkg::KEY_W-1:0]    key_ff, key_in;
   logic [kts_pkg::POS_W-1:0]    pos_ff, pos_in;
   logic                         pend_valid_ff, pend_valid_in;
   kts_pkg::record_type          pend_ff, pend_in;
   logic                         out_valid_ff, out_valid_in;
   kts_pkg::rsp_type             out_ff, out_in;

   kts_pkg::chain_ctrl_type      main_ctrl, wait_ctrl;
   kts_pkg::record_type          main_load, wait_load;
   kts_pkg::record_type          main_head, wait_head;
   kts_pkg::record_type          new_rec;
   logic                         out_free;
   logic                         req_ready;
   logic                         match;

   // table chain and unmatched-record chain
   kts_chain u_main (
      .clock     (clock),
      .ctrl      (main_ctrl),
      .load_data (main_load),
      .head      (main_head)
   );

   kts_chain u_wait (
      .clock     (clock),
      .ctrl      (wait_ctrl),
      .load_data (wait_load),
      .head      (wait_head)
   );

   assign out_free  = !out_valid_ff || rsp_bus.ready;
   assign req_ready = (state_ff == S_IDLE) && out_free;
   assign match     = (main_head.key == key_ff);

   always_comb begin
      new_rec.key  = req_bus.payload.key_in;
      new_rec.name = req_bus.payload.name_handle_in;
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      mocc_in       = mocc_ff;
      wocc_in       = wocc_ff;
      step_in       = step_ff;
      emit_in       = emit_ff;
      key_in        = key_ff;
      pos_in        = pos_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      out_in        = out_ff;
      out_valid_in  = out_valid_ff && !rsp_bus.ready;
      main_ctrl     = '0;
      wait_ctrl     = '0;
      main_load     = main_head;
      wait_load     = main_head;

      unique case (state_ff)
         S_IDLE: begin
            if (req_bus.valid && req_ready) begin
               unique case (req_bus.payload.action)
                  kts_pkg::ACT_APPEND: begin
                     out_valid_in = 1'b1;
                     out_in.last  = 1'b1;
                     if (count_ff < kts_pkg::CNT_W'(kts_pkg::DEPTH)) begin
                        main_ctrl.load     = 1'b1;
                        main_ctrl.load_idx = kts_pkg::IDX_W'(count_ff);
                        main_load          = new_rec;
                        count_in           = count_ff + 1'b1;
                        out_in.status          = kts_pkg::ST_OK;
                        out_in.key_out         = new_rec.key;
                        out_in.name_handle_out = new_rec.name;
                     end else begin
                        out_in.status          = kts_pkg::ST_FULL;
                        out_in.key_out         = '0;
                        out_in.name_handle_out = '0;
                     end
                  end
                  kts_pkg::ACT_SEARCH: begin
                     key_in        = req_bus.payload.key_in;
                     step_in       = '0;
                     mocc_in       = count_ff;
                     wocc_in       = '0;
                     emit_in       = '0;
                     pend_valid_in = 1'b0;
                     state_in      = S_SCAN;
                  end
                  kts_pkg::ACT_READ: begin
                     if (kts_pkg::CMP_W'(req_bus.payload.position_in) <
                         kts_pkg::CMP_W'(count_ff)) begin
                        pos_in        = req_bus.payload.position_in;
                        step_in       = '0;
                        pend_valid_in = 1'b0;
                        state_in      = S_READ;
                     end else begin
                        out_valid_in           = 1'b1;
                        out_in.status          = kts_pkg::ST_EMPTY;
                        out_in.key_out         = '0;
                        out_in.name_handle_out = '0;
                        out_in.last            = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_SCAN: begin
            if (step_ff < count_ff) begin
               if (out_free) begin
                  step_in         = step_ff + 1'b1;
                  main_ctrl.shift = 1'b1;
                  if (match) begin
                     // report the match, flushing the one held before it
                     if (emit_ff < kts_pkg::EMIT_W'(kts_pkg::MAX_RESULTS)) begin
                        if (pend_valid_ff) begin
                           out_valid_in           = 1'b1;
                           out_in.status          = kts_pkg::ST_OK;
                           out_in.key_out         = pend_ff.key;
                           out_in.name_handle_out = pend_ff.name;
                           out_in.last            = 1'b0;
                        end
                        pend_in       = main_head;
                        pend_valid_in = 1'b1;
                        emit_in       = emit_ff + 1'b1;
                     end
                     // match goes to the table tail behind earlier matches
                     main_ctrl.load     = 1'b1;
                     main_ctrl.load_idx = kts_pkg::IDX_W'(mocc_ff - 1'b1);
                     main_load          = main_head;
                     // first waiting record moves to the back of the wait chain
                     if (wocc_ff != '0) begin
                        wait_ctrl.shift    = 1'b1;
                        wait_ctrl.load     = 1'b1;
                        wait_ctrl.load_idx = kts_pkg::IDX_W'(wocc_ff - 1'b1);
                        wait_load          = wait_head;
                     end
                  end else begin
                     mocc_in            = mocc_ff - 1'b1;
                     wait_ctrl.load     = 1'b1;
                     wait_ctrl.load_idx = kts_pkg::IDX_W'(wocc_ff);
                     wait_load          = main_head;
                     wocc_in            = wocc_ff + 1'b1;
                  end
               end
            end else begin
               state_in = S_DRAIN;
            end
         end

         S_DRAIN: begin
            // unmatched records return behind the matches
            if (wocc_ff != '0) begin
               wait_ctrl.shift    = 1'b1;
               wocc_in            = wocc_ff - 1'b1;
               main_ctrl.load     = 1'b1;
               main_ctrl.load_idx = kts_pkg::IDX_W'(mocc_ff);
               main_load          = wait_head;
               mocc_in            = mocc_ff + 1'b1;
            end else begin
               state_in = S_FINISH;
            end
         end

         S_READ: begin
            // rotate the table once, catching the wanted position
            if (step_ff < count_ff) begin
               main_ctrl.shift    = 1'b1;
               main_ctrl.load     = 1'b1;
               main_ctrl.load_idx = kts_pkg::IDX_W'(count_ff - 1'b1);
               main_load          = main_head;
               if (kts_pkg::CMP_W'(step_ff) == kts_pkg::CMP_W'(pos_ff)) begin
                  pend_in       = main_head;
                  pend_valid_in = 1'b1;
               end
               step_in = step_ff + 1'b1;
            end else begin
               state_in = S_FINISH;
            end
         end

         S_FINISH: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_in.last  = 1'b1;
               if (pend_valid_ff) begin
                  out_in.status          = kts_pkg::ST_OK;
                  out_in.key_out         = pend_ff.key;
                  out_in.name_handle_out = pend_ff.name;
               end else begin
                  out_in.status          = kts_pkg::ST_NOT_FOUND;
                  out_in.key_out         = '0;
                  out_in.name_handle_out = '0;
               end
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         mocc_ff       <= '0;
         wocc_ff       <= '0;
         step_ff       <= '0;
         emit_ff       <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         mocc_ff       <= mocc_in;
         wocc_ff       <= wocc_in;
         step_ff       <= step_in;
         emit_ff       <= emit_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      pos_ff  <= pos_in;
      pend_ff <= pend_in;
      out_ff  <= out_in;
   end

   assign req_bus.ready   = req_ready;
   assign rsp_bus.valid   = out_valid_ff;
   assign rsp_bus.payload = out_ff;

endmodule
